/* hw/rtl/serial_line_editor_defines.svh */
// Assertion macros shared by the serial line editor checkers.
// Expects signals named clk and rst in the scope of each use.
`ifndef SERIAL_LINE_EDITOR_DEFINES_SVH
`define SERIAL_LINE_EDITOR_DEFINES_SVH

// Checked only outside reset.
`define SLE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("serial_line_editor check failed");

// Checked at every edge, reset included.
`define SLE_ASSERT_NORST(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) \
    else $error("serial_line_editor reset check failed");

`endif

/* hw/rtl/sle_pkg.sv */
// Types and constants of the serial line editor.
// No dependencies; used by all modules.
package sle_pkg;

  localparam int LEN_W = 6;  // line length, holds 0..63

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_BELL = 8'h07;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_BELL = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,  // echo and append at index len
    OP_DROP  = 2'd1,  // backspace on a non-empty line
    OP_BELL  = 2'd2,  // refused byte
    OP_LINE  = 2'd3   // carriage return, replay len bytes
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

/* hw/rtl/sle_rx_if.sv */
// Received byte channel: valid/ready plus the rx_byte payload.
// Depends on nothing.
interface sle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/sle_result_if.sv */
// Result channel: valid/ready plus kind, byte and last flag.
// Depends on nothing.
interface sle_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output result_kind, output data_byte, output last,
                  input ready);
  modport sink (input valid, input result_kind, input data_byte, input last,
                output ready);
endinterface

/* hw/rtl/serial_line_editor.sv */
// Top level of the serial line editor: front end, command queue, back end.
// Depends on sle_pkg, sle_rx_if, sle_result_if, sle_front, sle_cmd_fifo, sle_back.
//
//   channel   dir  payload                              per transfer
//   rx        in   rx_byte[7:0]                         one received byte
//   tx        out  result_kind[1:0] data_byte[7:0] last one result item
//   cfg       in   cfg_we, cfg_wdata (echo_enable)      register write
//
// The front end takes one byte a cycle while the two-entry command queue has room.
// The back end takes one edit command at a time from the queue; a carriage return
// echoes the CR if echo is on, then reads each stored byte from the store and puts it
// in the result register, then emits the end marker before the next command is taken.
// Reset empties the line and the queue and sets echo on; no clearing pass.
// A stalled tx holds the back end; the queue then fills and rx.ready drops.
module serial_line_editor #(
  parameter int LINE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  sle_rx_if.sink       rx,
  sle_result_if.source tx,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic          echo_en;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  sle_pkg::cmd_t cmd_in;
  sle_pkg::cmd_t cmd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_en <= 1'b1;
    end else if (cfg_we) begin
      echo_en <= cfg_wdata;
    end
  end

  sle_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (cmd_in)
  );

  sle_cmd_fifo u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (cmd_out),
    .empty   (q_empty)
  );

  sle_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .echo_en (echo_en),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cmd   (cmd_out),
    .tx      (tx)
  );

endmodule

/* hw/rtl/sle_front.sv */
// Front end: takes received bytes, tracks the line length, issues commands.
// Depends on sle_pkg and sle_rx_if.
module sle_front #(
  parameter int LINE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  sle_rx_if.sink        rx,
  input  logic          q_full,
  output logic          q_push,
  output sle_pkg::cmd_t q_cmd
);

  logic [sle_pkg::LEN_W-1:0] len;
  logic [sle_pkg::LEN_W-1:0] len_next;

  assign rx.ready = !q_full;
  assign q_push   = rx.valid && !q_full;

  always_comb begin
    q_cmd.data = rx.rx_byte;
    q_cmd.len  = len;
    q_cmd.op   = sle_pkg::OP_STORE;
    len_next   = len;
    if (rx.rx_byte == sle_pkg::CH_CR) begin
      q_cmd.op = sle_pkg::OP_LINE;
      len_next = '0;
    end else if (rx.rx_byte == sle_pkg::CH_BS) begin
      if (len != '0) begin
        q_cmd.op = sle_pkg::OP_DROP;
        len_next = len - 1'b1;
      end else begin
        q_cmd.op = sle_pkg::OP_BELL;
      end
    end else if (len == sle_pkg::LEN_W'(LINE_DEPTH)) begin
      q_cmd.op = sle_pkg::OP_BELL;
    end else begin
      len_next = len + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (q_push) begin
      len <= len_next;
    end
  end

endmodule

/* hw/rtl/sle_cmd_fifo.sv */
// Short command queue between front and back end.
// Depends on sle_pkg.
module sle_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sle_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output sle_pkg::cmd_t cmd_out,
  output logic          empty
);

  sle_pkg::cmd_t                  entries [sle_pkg::CMDQ_DEPTH];
  logic [sle_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [sle_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [sle_pkg::CMDQ_CNT_W-1:0] count;

  assign full    = count == sle_pkg::CMDQ_CNT_W'(sle_pkg::CMDQ_DEPTH);
  assign empty   = count == '0;
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sle_pkg::CMDQ_PTR_W'(sle_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sle_pkg::CMDQ_PTR_W'(sle_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/sle_back.sv */
// Back end: executes commands, owns the line store, drives the result register.
// Depends on sle_pkg and sle_result_if.
module sle_back #(
  parameter int LINE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          echo_en,
  input  logic          q_empty,
  output logic          q_pop,
  input  sle_pkg::cmd_t q_cmd,
  sle_result_if.source  tx
);

  localparam int IdxW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EMIT = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [7:0]                line_store [LINE_DEPTH];
  logic [7:0]                rd_data;
  logic [IdxW-1:0]           ptr;
  logic [sle_pkg::LEN_W-1:0] ptr_inc;
  logic [sle_pkg::LEN_W-1:0] cnt;

  logic       slot_free;
  logic       mem_we;
  logic       emit;
  logic [1:0] emit_kind;
  logic [7:0] emit_data;
  logic       emit_last;

  logic       tx_valid;
  logic [1:0] tx_kind;
  logic [7:0] tx_data;
  logic       tx_last;

  assign slot_free = !tx_valid || tx.ready;
  assign q_pop     = (state == S_IDLE) && !q_empty && slot_free;
  assign ptr_inc   = sle_pkg::LEN_W'(ptr) + 1'b1;

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    emit       = 1'b0;
    emit_kind  = sle_pkg::KIND_ECHO;
    emit_data  = q_cmd.data;
    emit_last  = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_cmd.op)
            sle_pkg::OP_STORE: begin
              mem_we = 1'b1;
              emit   = echo_en;
            end
            sle_pkg::OP_DROP: begin
              emit = echo_en;
            end
            sle_pkg::OP_BELL: begin
              emit      = echo_en;
              emit_kind = sle_pkg::KIND_BELL;
              emit_data = sle_pkg::CH_BELL;
            end
            sle_pkg::OP_LINE: begin
              // CR echo; line bytes and end marker follow
              emit       = echo_en;
              emit_last  = 1'b0;
              state_next = (q_cmd.len == '0) ? S_END : S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = sle_pkg::KIND_LINE;
          emit_data  = rd_data;
          emit_last  = 1'b0;
          state_next = (ptr_inc == cnt) ? S_END : S_RD;
        end
      end
      S_END: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_kind  = sle_pkg::KIND_END;
          emit_data  = sle_pkg::CH_NUL;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store is written only for appends, which never reach index LINE_DEPTH.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[IdxW'(q_cmd.len)] <= q_cmd.data;
    end
    if (state == S_RD) begin
      rd_data <= line_store[ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == sle_pkg::OP_LINE) begin
      ptr <= '0;
      cnt <= q_cmd.len;
    end else if (state == S_EMIT && slot_free) begin
      ptr <= IdxW'(ptr_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (emit) begin
      tx_valid <= 1'b1;
    end else if (tx.ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_kind <= emit_kind;
      tx_data <= emit_data;
      tx_last <= emit_last;
    end
  end

  assign tx.valid       = tx_valid;
  assign tx.result_kind = tx_kind;
  assign tx.data_byte   = tx_data;
  assign tx.last        = tx_last;

endmodule

/* hw/rtl/sle_checker.sv */
// Port-level checks of the serial line editor result stream, bound to the top.
// Depends on sle_pkg and serial_line_editor_defines.svh.
`include "serial_line_editor_defines.svh"

module sle_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_data,
  input logic       out_last
);

  `SLE_ASSERT_NORST(a_rst_idle, rst |=> !out_valid)
  `SLE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `SLE_ASSERT(a_bell_fmt, out_valid && out_kind == sle_pkg::KIND_BELL |-> out_data == sle_pkg::CH_BELL && out_last)
  `SLE_ASSERT(a_end_fmt, out_valid && out_kind == sle_pkg::KIND_END |-> out_data == sle_pkg::CH_NUL && out_last)
  `SLE_ASSERT(a_line_not_last, out_valid && out_kind == sle_pkg::KIND_LINE |-> !out_last)

endmodule

bind serial_line_editor sle_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tx.valid),
  .out_ready (tx.ready),
  .out_kind  (tx.result_kind),
  .out_data  (tx.data_byte),
  .out_last  (tx.last)
);
